[design/clr_pkg.sv]
// Shared types and constants for the command line receiver.
// Holds the command queue entry, the state encodings and the character classifiers.
// No dependencies.
package clr_pkg;

    localparam int CHAR_W      = 7;
    localparam int ARG_W       = 32;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 48;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_UP_A  = 8'd65;
    localparam logic [7:0] CH_UP_Z  = 8'd90;
    localparam logic [7:0] CH_LO_A  = 8'd97;
    localparam logic [7:0] CH_LO_Z  = 8'd122;

    typedef enum logic [1:0] {
        CMD_STORE,
        CMD_ERASE,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [CHAR_W-1:0]   ch;
    } line_cmd_t;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_SINGLE  = 2'd1,
        ST_NUMBER  = 2'd2,
        ST_INVALID = 2'd3
    } line_status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_EVAL,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_storable(input logic [7:0] c);
        return (c == CH_SPACE) || is_digit(c) ||
               ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
               ((c >= CH_LO_A) && (c <= CH_LO_Z));
    endfunction

endpackage

[design/clr_front.sv]
// Front end of the command line receiver: accepts received bytes and classifies them.
// Pushes store, erase and end-of-line commands into the command queue.
// Depends on clr_pkg.
module clr_front #(
    parameter int LINE_LEN = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [clr_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] rx_byte
    input  clr_pkg::queue_flags_t       q_flags,
    output logic                        push,
    output clr_pkg::line_cmd_t          push_data
);
    import clr_pkg::*;

    localparam int FW = $clog2(LINE_LEN + 1);

    logic [FW-1:0] count_reg, count_next;
    logic          accept;

    assign s_tready = !q_flags.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        count_next     = count_reg;
        push           = 1'b0;
        push_data.kind = CMD_STORE;
        push_data.ch   = s_tdata[CHAR_W-1:0];
        if (accept) begin
            if ((s_tdata == CH_CR) || (count_reg >= FW'(LINE_LEN))) begin
                // line end: the triggering byte is dropped
                push           = 1'b1;
                push_data.kind = CMD_END;
                count_next     = '0;
            end else if (s_tdata == CH_BS) begin
                if (count_reg != '0) begin
                    push           = 1'b1;
                    push_data.kind = CMD_ERASE;
                    count_next     = count_reg - FW'(1);
                end
            end else if (is_storable(s_tdata)) begin
                push       = 1'b1;
                count_next = count_reg + FW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

[design/clr_queue.sv]
// Short command queue between the front and back ends of the command line receiver.
// Fixed-depth first-in first-out buffer of line commands.
// Depends on clr_pkg.
module clr_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  clr_pkg::line_cmd_t    push_data,
    input  logic                  pop,
    output clr_pkg::line_cmd_t    pop_data,
    output clr_pkg::queue_flags_t q_flags
);
    import clr_pkg::*;

    line_cmd_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   used_reg, used_next;
    logic              do_push, do_pop;

    assign q_flags.full  = (used_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_flags.empty = (used_reg == '0);
    assign do_push       = push && !q_flags.full;
    assign do_pop        = pop && !q_flags.empty;
    assign pop_data      = slot_reg[rd_ptr_reg];

    always_comb begin
        used_next = used_reg;
        if (do_push && !do_pop) begin
            used_next = used_reg + (QPTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            used_next = used_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            used_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            used_reg <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/clr_back.sv]
// Back end of the command line receiver: line store, line walker and result register.
// Executes queued commands and parses the stored line at each line end.
// Depends on clr_pkg.
module clr_back #(
    parameter int LINE_LEN = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  clr_pkg::queue_flags_t        q_flags,
    input  clr_pkg::line_cmd_t           pop_data,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [clr_pkg::M_DATA_W-1:0] m_tdata    // [6:0] command_char, [38:7] argument,
                                                    // [40:39] line_status, [47:41] zero
);
    import clr_pkg::*;

    localparam int FW = $clog2(LINE_LEN + 1);
    localparam int IW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;

    logic [CHAR_W-1:0] mem [LINE_LEN];
    logic [CHAR_W-1:0] rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [CHAR_W-1:0] cmd_reg, cmd_next;
    logic [ARG_W-1:0]  acc_reg, acc_next;
    logic              seen_reg, seen_next;
    line_status_t      status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic              out_load, mem_we, out_free, last, done;
    logic [ARG_W+3:0]  mul_sum;
    logic [ARG_W-1:0]  acc_step;
    logic [7:0]        rd_byte;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign rd_byte  = {1'b0, rd_data_reg};
    assign last     = ((FW'(idx_reg) + FW'(1)) == fill_reg);

    // acc * 10 + digit, saturating
    assign mul_sum  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) +
                      (ARG_W+4)'(rd_data_reg[3:0]);
    assign acc_step = (|mul_sum[ARG_W+3:ARG_W]) ? '1 : mul_sum[ARG_W-1:0];

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        acc_next       = acc_reg;
        seen_next      = seen_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        mem_we         = 1'b0;
        pop            = 1'b0;
        done           = 1'b0;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE: begin
                if (!q_flags.empty) begin
                    pop = 1'b1;
                    case (pop_data.kind)
                        CMD_STORE: begin
                            mem_we    = 1'b1;
                            fill_next = fill_reg + FW'(1);
                        end
                        CMD_ERASE: begin
                            if (fill_reg != '0) begin
                                fill_next = fill_reg - FW'(1);
                            end
                        end
                        CMD_END: begin
                            cmd_next    = '0;
                            acc_next    = '0;
                            seen_next   = 1'b0;
                            idx_next    = '0;
                            status_next = ST_EMPTY;
                            state_next  = (fill_reg == '0) ? B_DONE : B_FETCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_FETCH: begin
                state_next = B_EVAL;
            end
            B_EVAL: begin
                if (idx_reg == '0) begin
                    cmd_next = rd_data_reg;
                    if (last) begin
                        status_next = ST_SINGLE;
                        done        = 1'b1;
                    end
                end else if (!seen_reg) begin
                    if (is_digit(rd_byte)) begin
                        acc_next  = ARG_W'(rd_data_reg[3:0]);
                        seen_next = 1'b1;
                    end else if (rd_byte != CH_SPACE) begin
                        status_next = ST_INVALID;
                        done        = 1'b1;
                    end
                end else begin
                    if (is_digit(rd_byte)) begin
                        acc_next = acc_step;
                    end else begin
                        status_next = ST_NUMBER;
                        done        = 1'b1;
                    end
                end
                if (!done && last) begin
                    status_next = seen_next ? ST_NUMBER : ST_INVALID;
                    done        = 1'b1;
                end
                if (done) begin
                    state_next = B_DONE;
                end else begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = B_FETCH;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    fill_next      = '0;
                    state_next     = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        cmd_reg    <= cmd_next;
        acc_reg    <= acc_next;
        seen_reg   <= seen_next;
        status_reg <= status_next;
        if (out_load) begin
            out_data_reg <= {(M_DATA_W-CHAR_W-ARG_W-2)'(0), status_reg, acc_reg, cmd_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[fill_reg[IW-1:0]] <= pop_data.ch;
        end
        rd_data_reg <= mem[idx_reg];
    end

endmodule

[design/command_line_receiver.sv]
// Top level of the command line receiver: front end, command queue and back end.
// Depends on clr_pkg, clr_front, clr_queue and clr_back.
//
// The block takes received serial bytes one per transaction on the s_ side and keeps an
// edited line of up to LINE_LEN characters. Space, digits and letters are stored, a
// backspace drops the last stored character, other bytes are ignored. A carriage return,
// or any byte that arrives while the line is full, ends the line and is itself dropped.
// Each line end yields one transaction on the m_ side with the first character, the
// decimal number read after it (leading spaces skipped, saturating at all ones) and the
// line status: empty, single character, command with number, or invalid. Then the line
// clears. An ordinary byte is executed by the back end as it is popped; a line end starts
// a walk over the line store, whose single registered read port is addressed in one state
// and its character evaluated in the next. A four-entry command queue sits
// between byte classification and execution, so bytes keep being accepted during a walk
// until the queue fills, and the result register frees the back end while a finished
// result waits to be taken. The line store needs no clearing after reset.
module command_line_receiver #(
    parameter int LINE_LEN = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [clr_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [clr_pkg::M_DATA_W-1:0] m_tdata    // [6:0] command_char, [38:7] argument,
                                                    // [40:39] line_status, [47:41] zero
);
    import clr_pkg::*;

    // queue handshake between front and back
    queue_flags_t q_flags;
    logic         push, pop;
    line_cmd_t    push_data, pop_data;

    // classify bytes and track the line length seen so far
    clr_front #(
        .LINE_LEN (LINE_LEN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_flags   (q_flags),
        .push      (push),
        .push_data (push_data)
    );

    // hold commands until the back end is free
    clr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_flags   (q_flags)
    );

    // store characters, walk the line at its end and drive the result
    clr_back #(
        .LINE_LEN (LINE_LEN)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_flags  (q_flags),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // never push into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_flags.full))
        else $error("command pushed into full queue");

    // an empty line reports no character and no number
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[40:39] == ST_EMPTY)) |-> (m_tdata[38:0] == '0))
        else $error("empty line result carries data");

    // only a command with a number carries an argument
    a_arg_only_number: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[40:39] != ST_NUMBER)) |-> (m_tdata[38:7] == '0))
        else $error("argument set without a number");

endmodule

[test/tb_command_line_receiver.sv]
// Self-checking testbench for command_line_receiver: drives received bytes, predicts each
// line-end transaction with its own line editor and parser, and compares field by field.
// Depends on clr_pkg and the command_line_receiver RTL.
module tb_command_line_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import clr_pkg::*;

    localparam int LINE_LEN     = 64;
    localparam int ITEM_TARGET  = 1350;  // stop offering bytes around here
    localparam int TAIL_ITEMS   = 150;   // last stretch runs with no idling
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to back up the queue
    localparam int DRAIN_CYCLES = 300;   // quiet watch for stray results after the last owed one

    // One expected line-end transaction, in the order of the m_tdata fields.
    typedef struct packed {
        logic [CHAR_W-1:0] cmd_char;
        logic [ARG_W-1:0]  arg_value;
        line_status_t      status;
    } line_result_t;

    // Line editor and parser, plus the queue of line results still owed by the block.
    class line_parse_board #(int LEN = 64);
        logic [CHAR_W-1:0] line_chars [LEN];
        int unsigned       fill;
        line_result_t      owed [$];
        int unsigned       errors;

        function bit is_numeral(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit can_store(logic [7:0] c);
            return c == CH_SPACE || is_numeral(c) ||
                   (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
        endfunction

        // Parse the edited line into one result, then clear the line.
        function void close_line();
            line_result_t      r;
            int unsigned       pos;
            longint unsigned   acc;
            r.cmd_char  = '0;
            r.arg_value = '0;
            r.status    = ST_EMPTY;
            if (fill == 1) begin
                r.cmd_char = line_chars[0];
                r.status   = ST_SINGLE;
            end else if (fill > 1) begin
                r.cmd_char = line_chars[0];
                pos = 1;
                while (pos < fill && line_chars[pos] == CH_SPACE[CHAR_W-1:0])
                    pos++;
                if (pos < fill && is_numeral({1'b0, line_chars[pos]})) begin
                    acc = 0;
                    while (pos < fill && is_numeral({1'b0, line_chars[pos]})) begin
                        acc = acc * 10 + longint'(line_chars[pos] - CH_ZERO[CHAR_W-1:0]);
                        // clamp one past the top so the product cannot wrap
                        if (acc > 64'hFFFF_FFFF)
                            acc = 64'h1_0000_0000;
                        pos++;
                    end
                    r.arg_value = (acc > 64'hFFFF_FFFF) ? '1 : acc[ARG_W-1:0];
                    r.status    = ST_NUMBER;
                end else begin
                    r.status = ST_INVALID;
                end
            end
            owed.push_back(r);
            fill = 0;
        endfunction

        // Apply one accepted byte to the line.
        function void note_byte(logic [7:0] b);
            if (b == CH_CR || fill >= LEN) begin
                close_line();
            end else if (b == CH_BS) begin
                if (fill > 0)
                    fill--;
            end else if (can_store(b)) begin
                line_chars[fill] = b[CHAR_W-1:0];
                fill++;
            end
        endfunction

        // Compare one accepted result transaction with the oldest owed result.
        function void check_result(logic [M_DATA_W-1:0] d);
            line_result_t want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result transaction, expected none, got %h",
                         $time, d);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (d[6:0] !== want.cmd_char) begin
                $display("%0t: command_char expected %h got %h", $time, want.cmd_char, d[6:0]);
                errors++;
            end
            if (d[38:7] !== want.arg_value) begin
                $display("%0t: argument expected %0d got %0d", $time, want.arg_value, d[38:7]);
                errors++;
            end
            if (d[40:39] !== want.status) begin
                $display("%0t: line_status expected %0d got %0d", $time, want.status,
                         d[40:39]);
                errors++;
            end
            if (d[47:41] !== '0) begin
                $display("%0t: pad bits expected 0 got %h", $time, d[47:41]);
                errors++;
            end
        endfunction

        function bit settled();
            return owed.size() == 0;
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    bit                  calm_tail  = 1'b0;  // no idling on either side once set
    int                  hold_seq   = 0;     // bump to request one long hold-off
    int unsigned         sent_count = 0;

    line_parse_board #(LINE_LEN) board;

    command_line_receiver #(
        .LINE_LEN (LINE_LEN)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] rx_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [6:0] command_char, [38:7] argument,
                               // [40:39] line_status, [47:41] zero
    );

    initial begin : clock_gen
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Random picks for line content.
    function automatic logic [7:0] pick_storable();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return 8'($urandom_range(CH_ZERO, CH_NINE));
            2:       return 8'($urandom_range(CH_UP_A, CH_UP_Z));
            default: return 8'($urandom_range(CH_LO_A, CH_LO_Z));
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 1))
            return 8'($urandom_range(CH_UP_A, CH_UP_Z));
        return 8'($urandom_range(CH_LO_A, CH_LO_Z));
    endfunction

    // A byte the block ignores: neither stored, nor a backspace, nor a line end.
    function automatic logic [7:0] pick_noise();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_BS || board.can_store(b));
        return b;
    endfunction

    // Offer one byte and hold it until the block takes the transaction.
    task automatic send_byte(input logic [7:0] b);
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_byte(b);
        sent_count++;
        if (sent_count + TAIL_ITEMS >= ITEM_TARGET)
            calm_tail <= 1'b1;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i]);
    endtask

    // Send a kept character, sometimes preceded by an ignored byte or by a
    // character that gets erased again.
    task automatic put_char(input logic [7:0] b);
        if ($urandom_range(0, 7) == 0)
            send_byte(pick_noise());
        if ($urandom_range(0, 9) == 0) begin
            send_byte(pick_storable());
            send_byte(CH_BS);
        end
        send_byte(b);
    endtask

    // Send one random line, mostly well-formed commands.
    task automatic send_line();
        int          pick;
        int          n;
        logic [7:0]  first;
        pick = $urandom_range(0, 19);
        if (pick <= 11) begin
            // command: first character, spaces, digits, trailing characters
            case ($urandom_range(0, 9))
                0:       first = CH_SPACE;
                1:       first = 8'($urandom_range(CH_ZERO, CH_NINE));
                default: first = pick_letter();
            endcase
            put_char(first);
            repeat ($urandom_range(0, 3)) put_char(CH_SPACE);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
            repeat (n) put_char(8'($urandom_range(CH_ZERO, CH_NINE)));
            repeat ($urandom_range(0, 3)) put_char(pick_storable());
            send_byte(CH_CR);
        end else if (pick == 12) begin
            // fill the line, then any byte ends it (a backspace too)
            n = 0;
            while (n < LINE_LEN) begin
                if (n > 0 && $urandom_range(0, 9) == 0) begin
                    send_byte(CH_BS);
                    n--;
                end else begin
                    send_byte(pick_storable());
                    n++;
                end
            end
            case ($urandom_range(0, 3))
                0:       send_byte(CH_BS);
                1:       send_byte(CH_CR);
                2:       send_byte(pick_storable());
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end else if (pick <= 14) begin
            // raw noise across the whole byte range
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            send_byte(CH_CR);
        end else if (pick <= 16) begin
            // empty or single-character line, with stray backspaces
            if ($urandom_range(0, 1))
                send_byte(CH_BS);
            if ($urandom_range(0, 1))
                put_char(pick_storable());
            send_byte(CH_CR);
        end else begin
            // broken: arbitrary mix of kept characters
            repeat ($urandom_range(1, 10)) put_char(pick_storable());
            send_byte(CH_CR);
        end
    endtask

    // Result side: check every taken transaction, and stall at random.
    initial begin : result_sink
        int stall_left;
        int seen_holds;
        stall_left = 0;
        seen_holds = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready)
                board.check_result(m_tdata);
            if (hold_seq != seen_holds) begin
                // long hold-off: the sender keeps going so the block backs up
                seen_holds = hold_seq;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        board = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Ignored bytes at both ends of the range, backspace on an empty line,
        // then an empty line.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_BS);
        send_byte(CH_CR);
        // single character
        send_text("A");
        send_byte(CH_CR);
        // digit as the command, only spaces after it: invalid
        send_text("5 ");
        send_byte(CH_CR);
        // space as the command, number with trailing characters
        send_text(" 8x");
        send_byte(CH_CR);
        // one past the top of the argument range: saturate
        send_text("c4294967296");
        send_byte(CH_CR);

        // Hold off the result side while short commands keep coming.
        hold_seq <= hold_seq + 1;
        repeat (10) begin
            send_byte(pick_letter());
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
            send_byte(CH_CR);
        end

        while (sent_count < ITEM_TARGET)
            send_line();
        s_tvalid <= 1'b0;

        // Drain owed results, then watch a while for stray transactions.
        while (!board.settled()) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
